FILE: hw/rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and constants of the sphere face subdivider.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

    localparam int COORD_W      = 24;
    localparam int RADIUS_W     = 23;
    localparam int DIV_W        = 4;
    localparam int MAX_DIVISIONS = 8;
    // normalized components stay below 2^29, so 30 bits signed
    localparam int Q_W          = 30;
    localparam int MAG_W        = Q_W - 1;
    localparam int STEP_W       = 5;
    localparam int SQRT_STEPS   = 32;
    localparam int QUOT_W       = 25;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p0_z;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p1_z;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p2_z;
    } t_face;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
        logic                      last_triangle;
    } t_tri;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GRID,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_STORE,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_GRID,
        OP_NORM,
        OP_SQ,
        OP_SQRT,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              store;
        logic [DIV_W-1:0]  c0;     // d - i - k
        logic [DIV_W-1:0]  ci;
        logic [DIV_W-1:0]  ck;
        logic [1:0]        comp;
        logic [1:0]        slot;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic norm_done;
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/sfs_face_if.sv
// ----------------------------------------------------------------------------
// sfs_face_if
// Valid/ready channel carrying one triangle face per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_face_if;
    logic           valid;
    logic           ready;
    sfs_pkg::t_face data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfs_tri_if.sv
// ----------------------------------------------------------------------------
// sfs_tri_if
// Valid/ready channel carrying one projected subtriangle per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfs_tri_if;
    logic          valid;
    logic          ready;
    sfs_pkg::t_tri data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sphere_face_subdivider_top.sv
// ----------------------------------------------------------------------------
// sphere_face_subdivider_top
// Splits a triangle face into D*D subtriangles projected onto a sphere.
// ----------------------------------------------------------------------------
// Usage:
//   i_face carries one face (three Q12.12 corners) per beat; o_tri returns
//   D*D subtriangle beats for it, the final one flagged last_triangle.
//   D is the divisions register, clamped to 1..8. sphere_radius sets the
//   projection radius. Write i_cfg_* registers only while idle (unenforced).
// Timing:
//   One face at a time: i_face.ready is high only when the block is idle.
//   Each vertex goes through one shared unit: grid point, normalize shift,
//   sum of squares, a bit-serial square root (one result bit per cycle),
//   then per component a multiply, a 25-step restoring divide and a store.
//   A zero-length grid point skips to the stores and yields zero components.
// Reset: synchronous, clears the sequencer and loads divisions 3 and
//   radius 5.0. While o_tri.ready is low the subtriangle is held and no
//   further work is done.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_face_subdivider_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_wr_en,
    input  wire                              i_cfg_index,
    input  wire [sfs_pkg::RADIUS_W-1:0]      i_cfg_data,
    sfs_face_if.sink                         i_face,
    sfs_tri_if.source                        o_tri
);

    localparam logic CFG_DIVISIONS = 1'b0;
    localparam logic CFG_RADIUS    = 1'b1;

    logic [sfs_pkg::DIV_W-1:0]    r_divisions;
    logic [sfs_pkg::RADIUS_W-1:0] r_radius;

    sfs_pkg::t_cmd    cmd;
    sfs_pkg::t_status status;
    logic             last;
    logic signed [sfs_pkg::COORD_W-1:0] vtx [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisions <= sfs_pkg::DIV_W'(3);
            r_radius    <= sfs_pkg::RADIUS_W'(20480);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIVISIONS: r_divisions <= i_cfg_data[sfs_pkg::DIV_W-1:0];
                CFG_RADIUS:    r_radius    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_divisions (r_divisions),
        .i_in_valid  (i_face.valid),
        .o_in_ready  (i_face.ready),
        .o_out_valid (o_tri.valid),
        .i_out_ready (o_tri.ready),
        .o_last      (last),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sfs_datapath u_dp (
        .i_clk    (i_clk),
        .i_face   (i_face.data),
        .i_radius (r_radius),
        .i_cmd    (cmd),
        .o_status (status),
        .o_vtx    (vtx)
    );

    assign o_tri.data.a_x = vtx[0][0];
    assign o_tri.data.a_y = vtx[0][1];
    assign o_tri.data.a_z = vtx[0][2];
    assign o_tri.data.b_x = vtx[1][0];
    assign o_tri.data.b_y = vtx[1][1];
    assign o_tri.data.b_z = vtx[1][2];
    assign o_tri.data.c_x = vtx[2][0];
    assign o_tri.data.c_y = vtx[2][1];
    assign o_tri.data.c_z = vtx[2][2];
    assign o_tri.data.last_triangle = last;

endmodule

`default_nettype wire

FILE: hw/rtl/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// Grid point, normalize shift, sum of squares, bit-serial square root and
// restoring divider that project one vertex component at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_datapath (
    input  wire                                  i_clk,
    input  wire sfs_pkg::t_face                  i_face,
    input  wire [sfs_pkg::RADIUS_W-1:0]          i_radius,
    input  wire sfs_pkg::t_cmd                   i_cmd,
    output sfs_pkg::t_status                     o_status,
    output logic signed [sfs_pkg::COORD_W-1:0]   o_vtx [3][3]
);

    localparam int CW = sfs_pkg::COORD_W;
    localparam int QW = sfs_pkg::Q_W;
    localparam int MW = sfs_pkg::MAG_W;
    localparam int RW = sfs_pkg::RADIUS_W;
    localparam int NW = RW + MW + 1;
    localparam int QTW = sfs_pkg::QUOT_W;

    logic signed [CW-1:0] r_p [3][3];
    logic signed [QW-1:0] r_q [3];
    logic [MW-1:0]        r_m;
    logic [63:0]          r_sx;
    logic [63:0]          r_sr;
    logic [QW-1:0]        r_rem;
    logic [QTW-1:0]       r_nlo;
    logic [QTW-1:0]       r_quot;
    logic signed [CW-1:0] r_vtx [3][3];

    logic signed [QW-1:0] n_q [3];
    logic [MW-1:0]        n_mag [3];
    logic [MW-1:0]        n_m;
    logic signed [QW-1:0] sel_q;
    logic [MW-1:0]        sel_mag;
    logic [QW-1:0]        len;
    logic [63:0]          sq_bit;
    logic [63:0]          sq_trial;
    logic [NW-1:0]        num;
    logic [QW:0]          div_t;
    logic signed [QTW:0]  sgn_q;
    logic signed [CW-1:0] sat_q;

    always_comb begin
        n_m = '0;
        for (int c = 0; c < 3; c++) begin
            n_q[c] = $signed(QW'({1'b0, i_cmd.c0})) * QW'(r_p[0][c])
                   + $signed(QW'({1'b0, i_cmd.ci})) * QW'(r_p[1][c])
                   + $signed(QW'({1'b0, i_cmd.ck})) * QW'(r_p[2][c]);
            n_mag[c] = n_q[c][QW-1] ? MW'(-n_q[c]) : MW'(n_q[c]);
            if (n_mag[c] > n_m) begin
                n_m = n_mag[c];
            end
        end
    end

    assign sel_q    = r_q[i_cmd.comp];
    assign sel_mag  = sel_q[QW-1] ? MW'(-sel_q) : MW'(sel_q);
    assign len      = r_sr[QW-1:0];
    assign sq_bit   = 64'h4000_0000_0000_0000 >> {i_cmd.step, 1'b0};
    assign sq_trial = r_sr + sq_bit;
    assign num      = NW'(i_radius) * NW'(sel_mag) + NW'(len >> 1);
    assign div_t    = {r_rem, r_nlo[QTW-1]};

    always_comb begin
        sgn_q = sel_q[QW-1] ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
        priority if (r_m == '0) begin
            sat_q = '0;
        end else if (sgn_q > $signed((QTW+1)'(2**(CW-1) - 1))) begin
            sat_q = CW'(2**(CW-1) - 1);
        end else if (sgn_q < -$signed((QTW+1)'(2**(CW-1)))) begin
            sat_q = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat_q = CW'(sgn_q);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sfs_pkg::OP_LOAD: begin
                r_p[0][0] <= i_face.p0_x;
                r_p[0][1] <= i_face.p0_y;
                r_p[0][2] <= i_face.p0_z;
                r_p[1][0] <= i_face.p1_x;
                r_p[1][1] <= i_face.p1_y;
                r_p[1][2] <= i_face.p1_z;
                r_p[2][0] <= i_face.p2_x;
                r_p[2][1] <= i_face.p2_y;
                r_p[2][2] <= i_face.p2_z;
            end
            sfs_pkg::OP_GRID: begin
                r_q  <= n_q;
                r_m  <= n_m;
                r_sx <= '0;
                r_sr <= '0;
            end
            sfs_pkg::OP_NORM: begin
                if (r_m[MW-1:MW-4] == '0) begin
                    r_m <= r_m << 4;
                    for (int c = 0; c < 3; c++) r_q[c] <= r_q[c] <<< 4;
                end else begin
                    r_m <= r_m << 1;
                    for (int c = 0; c < 3; c++) r_q[c] <= r_q[c] <<< 1;
                end
            end
            sfs_pkg::OP_SQ: begin
                r_sx <= r_sx + (64'(sel_mag) * 64'(sel_mag));
            end
            sfs_pkg::OP_SQRT: begin
                if (r_sx >= sq_trial) begin
                    r_sx <= r_sx - sq_trial;
                    r_sr <= (r_sr >> 1) + sq_bit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
            end
            sfs_pkg::OP_MUL: begin
                r_rem  <= QW'(num[NW-1:QTW]);
                r_nlo  <= num[QTW-1:0];
                r_quot <= '0;
            end
            sfs_pkg::OP_DIV: begin
                r_nlo <= r_nlo << 1;
                if (div_t >= {1'b0, len}) begin
                    r_rem  <= QW'(div_t - {1'b0, len});
                    r_quot <= {r_quot[QTW-2:0], 1'b1};
                end else begin
                    r_rem  <= QW'(div_t);
                    r_quot <= {r_quot[QTW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.store) begin
            r_vtx[i_cmd.slot][i_cmd.comp] <= sat_q;
        end
    end

    assign o_status.zero      = (r_m == '0);
    assign o_status.norm_done = r_m[MW-1];
    assign o_vtx              = r_vtx;

endmodule

`default_nettype wire

FILE: hw/rtl/sfs_ctrl.sv
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer: walks the subtriangles of a face in output order and steps the
// datapath through each vertex projection.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ctrl (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [sfs_pkg::DIV_W-1:0]        i_divisions,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic                            o_last,
    output sfs_pkg::t_cmd                   o_cmd,
    input  wire sfs_pkg::t_status           i_status
);

    localparam int DW = sfs_pkg::DIV_W;
    localparam int SW = sfs_pkg::STEP_W;

    sfs_pkg::t_state r_state, n_state;
    logic [DW-1:0] r_d, n_d;
    logic [DW-1:0] r_row, n_row;
    logic [DW-1:0] r_j, n_j;
    logic          r_half, n_half;
    logic [1:0]    r_vtx, n_vtx;
    logic [1:0]    r_comp, n_comp;
    logic [SW-1:0] r_step, n_step;

    logic [DW-1:0] d_eff;
    logic [DW-1:0] vi, vk;

    always_comb begin
        priority if (i_divisions == '0) begin
            d_eff = DW'(1);
        end else if (i_divisions > DW'(sfs_pkg::MAX_DIVISIONS)) begin
            d_eff = DW'(sfs_pkg::MAX_DIVISIONS);
        end else begin
            d_eff = i_divisions;
        end
    end

    // grid coordinates of the current vertex
    always_comb begin
        unique case ({r_half, r_vtx})
            3'b000:  begin vi = r_j;         vk = r_row - r_j;          end
            3'b001:  begin vi = r_j - 1'b1;  vk = r_row - r_j + 1'b1;   end
            3'b010:  begin vi = r_j - 1'b1;  vk = r_row - r_j;          end
            3'b100:  begin vi = r_j;         vk = r_row - 1'b1 - r_j;   end
            3'b101:  begin vi = r_j;         vk = r_row - r_j;          end
            3'b110:  begin vi = r_j - 1'b1;  vk = r_row - r_j;          end
            default: begin vi = '0;          vk = '0;                   end
        endcase
    end

    assign o_last = (r_row == r_d) && (r_j == DW'(1)) && (r_half || r_d == DW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfs_pkg::S_IDLE;
            r_d     <= '0;
            r_row   <= '0;
            r_j     <= '0;
            r_half  <= 1'b0;
            r_vtx   <= '0;
            r_comp  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_d     <= n_d;
            r_row   <= n_row;
            r_j     <= n_j;
            r_half  <= n_half;
            r_vtx   <= n_vtx;
            r_comp  <= n_comp;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_row   = r_row;
        n_j     = r_j;
        n_half  = r_half;
        n_vtx   = r_vtx;
        n_comp  = r_comp;
        n_step  = r_step;

        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.op    = sfs_pkg::OP_NONE;
        o_cmd.store = 1'b0;
        o_cmd.c0    = r_d - vi - vk;
        o_cmd.ci    = vi;
        o_cmd.ck    = vk;
        o_cmd.comp  = r_comp;
        o_cmd.slot  = r_vtx;
        o_cmd.step  = r_step;

        unique case (r_state)
            sfs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = sfs_pkg::OP_LOAD;
                    n_d      = d_eff;
                    n_row    = DW'(1);
                    n_j      = DW'(1);
                    n_half   = 1'b0;
                    n_vtx    = '0;
                    n_state  = sfs_pkg::S_GRID;
                end
            end
            sfs_pkg::S_GRID: begin
                o_cmd.op = sfs_pkg::OP_GRID;
                n_state  = sfs_pkg::S_NORM;
            end
            sfs_pkg::S_NORM: begin
                n_comp = '0;
                n_step = '0;
                priority if (i_status.zero) begin
                    n_state = sfs_pkg::S_STORE;
                end else if (i_status.norm_done) begin
                    n_state = sfs_pkg::S_SQ;
                end else begin
                    o_cmd.op = sfs_pkg::OP_NORM;
                end
            end
            sfs_pkg::S_SQ: begin
                o_cmd.op = sfs_pkg::OP_SQ;
                if (r_comp == 2'd2) begin
                    n_comp  = '0;
                    n_state = sfs_pkg::S_SQRT;
                end else begin
                    n_comp = r_comp + 1'b1;
                end
            end
            sfs_pkg::S_SQRT: begin
                o_cmd.op = sfs_pkg::OP_SQRT;
                n_step   = r_step + 1'b1;
                if (r_step == SW'(sfs_pkg::SQRT_STEPS - 1)) begin
                    n_state = sfs_pkg::S_MUL;
                end
            end
            sfs_pkg::S_MUL: begin
                o_cmd.op = sfs_pkg::OP_MUL;
                n_step   = '0;
                n_state  = sfs_pkg::S_DIV;
            end
            sfs_pkg::S_DIV: begin
                o_cmd.op = sfs_pkg::OP_DIV;
                n_step   = r_step + 1'b1;
                if (r_step == SW'(sfs_pkg::QUOT_W - 1)) begin
                    n_state = sfs_pkg::S_STORE;
                end
            end
            sfs_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_comp == 2'd2) begin
                    n_comp = '0;
                    if (r_vtx == 2'd2) begin
                        n_state = sfs_pkg::S_OUT;
                    end else begin
                        n_vtx   = r_vtx + 1'b1;
                        n_state = sfs_pkg::S_GRID;
                    end
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = i_status.zero ? sfs_pkg::S_STORE : sfs_pkg::S_MUL;
                end
            end
            sfs_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_vtx   = '0;
                    n_state = sfs_pkg::S_GRID;
                    if (r_j > DW'(1)) begin
                        n_j = r_j - 1'b1;
                    end else if (!r_half && r_row > DW'(1)) begin
                        n_half = 1'b1;
                        n_j    = r_row - 1'b1;
                    end else if (r_row == r_d) begin
                        n_state = sfs_pkg::S_IDLE;
                    end else begin
                        n_row  = r_row + 1'b1;
                        n_half = 1'b0;
                        n_j    = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = sfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks of the subdivider handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_last
);

    // a pending result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat withdrawn before accept");

    // one face at a time: no new face while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // a taken face blocks further input for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after face accept");

    // nothing more is produced after the last subtriangle leaves
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("activity after last subtriangle");

endmodule

bind sphere_face_subdivider_top sfs_checker u_sfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_face.valid),
    .i_in_ready  (i_face.ready),
    .i_out_valid (o_tri.valid),
    .i_out_ready (o_tri.ready),
    .i_out_last  (o_tri.data.last_triangle)
);

`default_nettype wire
